/* sv/assert_macros.svh */
// Assertion macros used by the packer top level.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

/* sv/qwbp_pkg.sv */
// Shared types, constants and the exact single-to-half scale conversion
// for the quantized weight block packer. Depends on nothing.
package qwbp_pkg;

    localparam int BLOCK_ELEMENTS = 32;
    localparam int ELEM_W         = $clog2(BLOCK_ELEMENTS);
    localparam int PAYLOAD_BYTES  = 32;
    localparam int FRAME_BYTES    = PAYLOAD_BYTES + 2;
    localparam int REM_W          = $clog2(FRAME_BYTES + 1);
    localparam int FIFO_DEPTH     = 2;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] PROF_Q4 = 2'd0;
    localparam logic [1:0] PROF_Q5 = 2'd1;
    localparam logic [1:0] PROF_Q8 = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SCALE = 2'd2;

    localparam logic [1:0] CFG_PROFILE       = 2'd0;
    localparam logic [1:0] CFG_QUANT_BITS    = 2'd1;
    localparam logic [1:0] CFG_SIGNED_QUANTS = 2'd2;

    localparam logic [REM_W-1:0] Q4_BYTES = REM_W'(18);
    localparam logic [REM_W-1:0] Q5_BYTES = REM_W'(22);
    localparam logic [REM_W-1:0] Q8_BYTES = REM_W'(34);

    localparam logic [12:0] HALF_DROP_MASK = 13'h1fff;
    localparam logic [7:0]  EXP_MIN        = 8'd103;
    localparam logic [7:0]  EXP_MAX        = 8'd142;
    localparam logic [7:0]  EXP_NORMAL     = 8'd113;
    localparam logic [7:0]  EXP_REBIAS     = 8'd112;
    localparam logic [7:0]  EXP_SUB_BASE   = 8'd126;

    typedef struct packed {
        logic [1:0]  prof;
        logic [7:0]  val;
        logic        out_of_range;
        logic        exact;
        logic [15:0] half;
    } qwbp_item_t;

    // {exact, half}
    function automatic logic [16:0] f2h(input logic [31:0] b);
        logic [7:0]  e;
        logic [7:0]  ediff;
        logic [4:0]  sh;
        logic [23:0] m;
        logic [23:0] mask;
        logic [16:0] r;
        e     = b[30:23];
        ediff = 8'd0;
        sh    = 5'd0;
        m     = {1'b1, b[22:0]};
        mask  = 24'd0;
        r     = 17'd0;
        if (b[30:0] == 31'd0)
        begin
            r = {1'b1, b[31], 15'd0};
        end
        else if (e < EXP_MIN || e > EXP_MAX)
        begin
            r = 17'd0;
        end
        else if (e >= EXP_NORMAL)
        begin
            ediff = e - EXP_REBIAS;
            r = {(b[12:0] & HALF_DROP_MASK) == 13'd0, b[31], ediff[4:0], b[22:13]};
        end
        else
        begin
            ediff = EXP_SUB_BASE - e;
            sh    = ediff[4:0];
            mask  = (24'd1 << sh) - 24'd1;
            r = {(m & mask) == 24'd0, b[31], 15'(m >> sh)};
        end
        return r;
    endfunction

endpackage

/* sv/qwbp_front.sv */
// Front end: configuration registers and item classification
// (offset value, range check, scale conversion). Uses qwbp_pkg.
module qwbp_front import qwbp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata,
    input  logic [7:0]  raw_quant,
    input  logic [15:0] zero_point,
    input  logic [31:0] scale_bits,
    output qwbp_item_t  item
);

    logic [1:0]  profile_reg;
    logic [3:0]  quant_bits_reg;
    logic        signed_quants_reg;
    logic [3:0]  qb_sat;
    logic [8:0]  raw_mask;
    logic [8:0]  raw_m;
    logic [8:0]  sign_wt;
    logic        neg;
    logic [16:0] q;
    logic        [1:0] prof;
    logic [16:0] conv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_reg       <= PROF_Q4;
            quant_bits_reg    <= 4'd4;
            signed_quants_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROFILE:       profile_reg       <= cfg_wdata[1:0];
                CFG_QUANT_BITS:    quant_bits_reg    <= cfg_wdata;
                CFG_SIGNED_QUANTS: signed_quants_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (quant_bits_reg < 4'd2)
            qb_sat = 4'd2;
        else if (quant_bits_reg > 4'd8)
            qb_sat = 4'd8;
        else
            qb_sat = quant_bits_reg;
        sign_wt  = 9'd1 << qb_sat;
        raw_mask = sign_wt - 9'd1;
        raw_m    = {1'b0, raw_quant} & raw_mask;
        neg      = signed_quants_reg && raw_m[3'(qb_sat - 4'd1)];
        q        = {8'd0, raw_m} - (neg ? {8'd0, sign_wt} : 17'd0)
                   - {zero_point[15], zero_point};
        prof     = (profile_reg == 2'd3) ? PROF_Q8 : profile_reg;
        conv     = f2h(scale_bits);

        item.prof  = prof;
        item.exact = conv[16];
        item.half  = conv[15:0];
        unique case (prof)
            PROF_Q4:
            begin
                item.out_of_range = $signed(q) < -17'sd8 || $signed(q) > 17'sd7;
                item.val          = q[7:0] + 8'd8;
            end
            PROF_Q5:
            begin
                item.out_of_range = $signed(q) < -17'sd16 || $signed(q) > 17'sd15;
                item.val          = q[7:0] + 8'd16;
            end
            default:
            begin
                item.out_of_range = $signed(q) < -17'sd128 || $signed(q) > 17'sd127;
                item.val          = q[7:0];
            end
        endcase
    end

endmodule

/* sv/qwbp_fifo.sv */
// Two-entry item queue between the front end and the packer.
// Uses qwbp_pkg for the item type and depth.
module qwbp_fifo import qwbp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr,
    input  qwbp_item_t wr_item,
    output logic       full,
    input  logic       rd,
    output qwbp_item_t rd_item,
    output logic       empty
);

    qwbp_item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   cnt_reg;
    logic                    do_wr;
    logic                    do_rd;

    assign full    = cnt_reg == FIFO_CNT_W'(FIFO_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

/* sv/qwbp_back.sv */
// Back end: packs classified items into the block buffer, keeps the sticky
// status and block scale, and shifts finished blocks out. Uses qwbp_pkg.
module qwbp_back import qwbp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  qwbp_item_t  item,
    input  logic        item_valid,
    output logic        take,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  out_byte,
    output logic        block_last,
    output logic [1:0]  block_status
);

    logic [7:0]        pack_reg  [PAYLOAD_BYTES];
    logic [7:0]        pack_next [PAYLOAD_BYTES];
    logic [7:0]        upd       [PAYLOAD_BYTES];
    logic [7:0]        sh_reg    [FRAME_BYTES];
    logic [7:0]        sh_next   [FRAME_BYTES];
    logic [ELEM_W-1:0] count_reg;
    logic [ELEM_W-1:0] count_next;
    logic [15:0]       scale_reg;
    logic [15:0]       scale_next;
    logic [1:0]        sticky_reg;
    logic [1:0]        sticky_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic              last_elem;
    logic              load;
    logic              do_pop;
    logic [7:0]        nib;

    assign last_elem    = count_reg == ELEM_W'(BLOCK_ELEMENTS - 1);
    assign take         = item_valid && (!last_elem || rem_reg == '0);
    assign load         = take && last_elem;
    assign empty        = rem_reg == '0;
    assign do_pop       = pop && !empty;
    assign out_byte     = sh_reg[0];
    assign block_last   = rem_reg == REM_W'(1);
    assign block_status = status_reg;

    always_comb
    begin
        nib = count_reg[4] ? {item.val[3:0], 4'd0} : {4'd0, item.val[3:0]};
        for (int j = 0; j < PAYLOAD_BYTES; j++)
        begin
            upd[j] = pack_reg[j];
            unique case (item.prof)
                PROF_Q4:
                begin
                    if (j < 16 && count_reg[3:0] == 4'(j))
                        upd[j] = pack_reg[j] | nib;
                end
                PROF_Q5:
                begin
                    if (j >= 4 && j < 20 && count_reg[3:0] == 4'(j - 4))
                        upd[j] = pack_reg[j] | nib;
                    if (j < 4 && count_reg[4:3] == 2'(j))
                        upd[j] = pack_reg[j] | (8'(item.val[4]) << count_reg[2:0]);
                end
                default:
                begin
                    if (count_reg == ELEM_W'(j))
                        upd[j] = item.val;
                end
            endcase
        end

        sticky_next = sticky_reg;
        if (!item.exact)
            sticky_next = ST_SCALE;
        else if (item.out_of_range && sticky_reg == ST_OK)
            sticky_next = ST_RANGE;

        scale_next  = scale_reg;
        count_next  = count_reg;
        status_next = status_reg;
        rem_next    = rem_reg;
        pack_next   = pack_reg;
        sh_next     = sh_reg;

        if (do_pop)
        begin
            for (int k = 0; k < FRAME_BYTES - 1; k++)
                sh_next[k] = sh_reg[k + 1];
            sh_next[FRAME_BYTES - 1] = 8'd0;
            rem_next = rem_reg - 1'b1;
        end

        if (take)
        begin
            if (count_reg == '0)
                scale_next = item.exact ? item.half : 16'd0;
            count_next = count_reg + 1'b1;
            if (load)
            begin
                for (int j = 0; j < PAYLOAD_BYTES; j++)
                begin
                    pack_next[j]  = 8'd0;
                    sh_next[j + 2] = upd[j];
                end
                sh_next[0]  = scale_reg[7:0];
                sh_next[1]  = scale_reg[15:8];
                status_next = sticky_next;
                unique case (item.prof)
                    PROF_Q4: rem_next = Q4_BYTES;
                    PROF_Q5: rem_next = Q5_BYTES;
                    default: rem_next = Q8_BYTES;
                endcase
            end
            else
            begin
                pack_next = upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < PAYLOAD_BYTES; j++)
                pack_reg[j] <= 8'd0;
            count_reg  <= '0;
            scale_reg  <= 16'd0;
            sticky_reg <= ST_OK;
            status_reg <= ST_OK;
            rem_reg    <= '0;
        end
        else
        begin
            pack_reg   <= pack_next;
            count_reg  <= count_next;
            scale_reg  <= scale_next;
            if (take)
                sticky_reg <= sticky_next;
            status_reg <= status_next;
            rem_reg    <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

endmodule

/* sv/quant_weight_block_packer_top.sv */
// Quantized weight block packer: Q4_0 / Q5_0 / Q8_0 blocks of 32 weights.
// A block's first byte shows once its last item is taken from the queue and loaded
// into the output shift register, which waits until the previous block's last byte is popped.
// Throughput: one item per cycle; a block's last item waits until the previous block's
// bytes are all popped, which go out one per cycle while pop is high (18, 22 or 34).
// Reset clears the config to Q4_0, 4 bits, unsigned; buffer, count and status to 0.
`include "assert_macros.svh"

module quant_weight_block_packer_top import qwbp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  raw_quant,
    input  logic [15:0] zero_point,
    input  logic [31:0] scale_bits,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  out_byte,
    output logic        block_last,
    output logic [1:0]  block_status
);

    qwbp_item_t fr_item;
    qwbp_item_t q_item;
    logic       q_empty;
    logic       q_take;

    qwbp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .raw_quant  (raw_quant),
        .zero_point (zero_point),
        .scale_bits (scale_bits),
        .item       (fr_item)
    );

    qwbp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (push),
        .wr_item (fr_item),
        .full    (full),
        .rd      (q_take),
        .rd_item (q_item),
        .empty   (q_empty)
    );

    qwbp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (q_item),
        .item_valid   (!q_empty),
        .take         (q_take),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .block_last   (block_last),
        .block_status (block_status)
    );

    `ASSERT_NEXT(a_last_drains, pop && !empty && block_last, empty)
    `ASSERT_NEXT(a_mid_block_stays, pop && !empty && !block_last, !empty)
    `ASSERT_NEXT(a_status_sticky, !empty && block_status != ST_OK, empty || block_status != ST_OK)

endmodule

/* tb/quant_weight_block_packer_top_tb.sv */
// Self-checking testbench for quant_weight_block_packer_top: queue-fed driver,
// byte monitor and an independent block packing predictor.
// Depends on qwbp_pkg and the packer RTL only.
module quant_weight_block_packer_top_tb;
    import qwbp_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [1:0] PROF_SPARE = 2'd3;

    typedef enum int { IN_RANGE, VALUES_WILD, SCALES_WILD } weight_kind_t;

    typedef struct packed {
        logic [7:0]  raw;
        logic [15:0] zp;
        logic [31:0] scale;
    } weight_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } block_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_wdata = '0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  raw_quant = '0;
    logic [15:0] zero_point = '0;
    logic [31:0] scale_bits = '0;
    logic        pop = 1'b0;
    logic        empty;
    logic [7:0]  out_byte;
    logic        block_last;
    logic [1:0]  block_status;

    quant_weight_block_packer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .push         (push),
        .full         (full),
        .raw_quant    (raw_quant),
        .zero_point   (zero_point),
        .scale_bits   (scale_bits),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .block_last   (block_last),
        .block_status (block_status)
    );

    always #4 clk = ~clk;

    weight_t     weights_pending[$];
    block_byte_t bytes_due[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_req = 1'b0;

    // Predictor state and its copy of the registers
    logic [1:0]  cfg_prof = PROF_Q4;
    logic [3:0]  cfg_qbits = 4'd4;
    logic        cfg_signed = 1'b0;
    logic [7:0]  pack_buf [0:FRAME_BYTES-1] = '{default: 8'd0};
    int          elem_count = 0;
    logic [15:0] block_scale = '0;
    logic [1:0]  sticky = ST_OK;

    function automatic bit single_to_half(input logic [31:0] f, output logic [15:0] h);
        logic [7:0]  e;
        int          sh;
        logic [23:0] m;
        e = f[30:23];
        m = {1'b1, f[22:0]};
        h = {f[31], 15'd0};
        if (f[30:0] == 31'd0)
            return 1'b1;
        if (e < EXP_MIN || e > EXP_MAX)
            return 1'b0;
        if (e >= EXP_NORMAL)
        begin
            if (f[12:0] != 13'd0)
                return 1'b0;
            h = {f[31], 5'(e - EXP_REBIAS), f[22:13]};
            return 1'b1;
        end
        sh = int'(EXP_SUB_BASE - e);
        if ((m & ((24'd1 << sh) - 24'd1)) != 24'd0)
            return 1'b0;
        h = {f[31], 15'(m >> sh)};
        return 1'b1;
    endfunction

    function automatic int field_value(input logic [7:0] rq);
        int bits;
        int f;
        bits = cfg_qbits < 2 ? 2 : (cfg_qbits > 8 ? 8 : int'(cfg_qbits));
        f = int'(rq) & ((1 << bits) - 1);
        if (cfg_signed && f[bits-1])
            f -= 1 << bits;
        return f;
    endfunction

    task automatic pack_weight(input logic [7:0] rq, input logic [15:0] zp,
                               input logic [31:0] sc);
        int          q;
        int          lim;
        int          n;
        int          slot;
        logic [1:0]  prof;
        logic [15:0] h;
        logic [7:0]  u;
        bit          ok;
        block_byte_t b;
        q = field_value(rq) - int'($signed(zp));
        prof = (cfg_prof == PROF_Q4 || cfg_prof == PROF_Q5) ? cfg_prof : PROF_Q8;
        ok = single_to_half(sc, h);
        if (elem_count == 0)
            block_scale = ok ? h : 16'd0;
        lim = prof == PROF_Q4 ? 8 : (prof == PROF_Q5 ? 16 : 128);
        if (!ok)
            sticky = ST_SCALE;
        else if ((q < -lim || q >= lim) && sticky == ST_OK)
            sticky = ST_RANGE;
        if (prof == PROF_Q8)
        begin
            pack_buf[2 + elem_count] = q[7:0];
        end
        else
        begin
            u = 8'(q + lim);
            slot = (prof == PROF_Q4 ? 2 : 6) + elem_count % 16;
            pack_buf[slot] |= elem_count < 16 ? {4'd0, u[3:0]} : {u[3:0], 4'd0};
            if (prof == PROF_Q5)
                pack_buf[2 + elem_count / 8] |= 8'(u[4]) << (elem_count % 8);
        end
        if (elem_count < BLOCK_ELEMENTS - 1)
        begin
            elem_count++;
        end
        else
        begin
            n = prof == PROF_Q4 ? int'(Q4_BYTES) :
                (prof == PROF_Q5 ? int'(Q5_BYTES) : int'(Q8_BYTES));
            pack_buf[0] = block_scale[7:0];
            pack_buf[1] = block_scale[15:8];
            for (int k = 0; k < n; k++)
            begin
                b.data = pack_buf[k];
                b.last = (k == n - 1);
                b.status = sticky;
                bytes_due.push_back(b);
            end
            pack_buf = '{default: 8'd0};
            elem_count = 0;
        end
    endtask

    function automatic logic [31:0] exact_scale();
        logic [31:0] f;
        logic [23:0] m;
        int          e;
        f = '0;
        f[31] = 1'($urandom);
        case ($urandom_range(9, 0))
            0: ;
            1, 2, 3:
            begin
                e = $urandom_range(112, 103);
                m = 24'($urandom) | 24'h800000;
                m &= ~((24'd1 << (126 - e)) - 24'd1);
                f[30:23] = 8'(e);
                f[22:0] = m[22:0];
            end
            default:
            begin
                f[30:23] = 8'($urandom_range(142, 113));
                f[22:13] = 10'($urandom);
            end
        endcase
        return f;
    endfunction

    function automatic weight_t next_weight(input weight_kind_t kind);
        weight_t w;
        int      lim;
        int      q;
        w.raw = 8'($urandom);
        w.zp = 16'($urandom);
        w.scale = (kind == SCALES_WILD && $urandom_range(2, 0) == 0) ? $urandom
                                                                      : exact_scale();
        if (kind == IN_RANGE)
        begin
            lim = cfg_prof == PROF_Q4 ? 8 : (cfg_prof == PROF_Q5 ? 16 : 128);
            q = int'($urandom_range(2 * lim - 1, 0)) - lim;
            w.zp = 16'(field_value(w.raw) - q);
        end
        return w;
    endfunction

    function automatic void add_weight(input logic [7:0] rq, input logic [15:0] zp,
                                       input logic [31:0] sc);
        weights_pending.push_back('{raw: rq, zp: zp, scale: sc});
    endfunction

    function automatic void queue_weights(input int n, input weight_kind_t kind);
        for (int k = 0; k < n; k++)
            weights_pending.push_back(next_weight(kind));
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic set_config(input logic [1:0] prof, input logic [3:0] qbits,
                              input logic [3:0] sgn);
        write_reg(CFG_PROFILE, {2'd0, prof});
        write_reg(CFG_QUANT_BITS, qbits);
        write_reg(CFG_SIGNED_QUANTS, sgn);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (weights_pending.size() != 0 || push || bytes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        weight_t w;
        if (!rst_n)
        begin
            push <= 1'b0;
            raw_quant <= '0;
            zero_point <= '0;
            scale_bits <= '0;
        end
        else if (!push || !full)
        begin
            if (weights_pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                w = weights_pending.pop_front();
                push <= 1'b1;
                raw_quant <= w.raw;
                zero_point <= w.zp;
                scale_bits <= w.scale;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Receiver
    int hold_left;
    bit hold_done;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            pop <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= $urandom_range(99, 0) >= recv_stall_pct;
        end
    end

    // Monitor and watchdog
    always @(posedge clk)
    begin : monitor
        block_byte_t want;
        int          quiet;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PROFILE:       cfg_prof = cfg_wdata[1:0];
                    CFG_QUANT_BITS:    cfg_qbits = cfg_wdata;
                    CFG_SIGNED_QUANTS: cfg_signed = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                if (bytes_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected byte: expected none, actual %h", $time, out_byte);
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (out_byte !== want.data)
                    begin
                        errors++;
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want.data, out_byte);
                    end
                    if (block_last !== want.last)
                    begin
                        errors++;
                        $display("%0t: block_last expected %b actual %b",
                                 $time, want.last, block_last);
                    end
                    if (block_status !== want.status)
                    begin
                        errors++;
                        $display("%0t: block_status expected %0d actual %0d",
                                 $time, want.status, block_status);
                    end
                end
            end
            if (push && !full)
                pack_weight(raw_quant, zero_point, scale_bits);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("quant_weight_block_packer_top_tb failed");
                $finish;
            end
        end
        else
        begin
            quiet = 0;
        end
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Q4_0, unsigned 4-bit, reset settings: range and scale extremes
        add_weight(8'h00, 16'h0008, 32'h477FE000);
        add_weight(8'h0F, 16'h0008, 32'h80000000);
        add_weight(8'hFF, 16'h000F, 32'h00000000);
        add_weight(8'hF0, 16'h0000, 32'h33800000);
        add_weight(8'h07, 16'h0003, 32'h387FC000);
        add_weight(8'h33, 16'h0004, 32'h38800000);
        add_weight(8'hA5, 16'h0005, 32'hBF800000);
        add_weight(8'h5A, 16'h0006, 32'hC77FE000);
        queue_weights(24, IN_RANGE);
        settle();

        set_config(PROF_Q5, 4'd8, 4'd1);
        send_idle_pct = 73;
        queue_weights(30, IN_RANGE);
        settle();

        set_config(PROF_Q8, 4'd2, 4'd0);
        send_idle_pct = 0;
        recv_stall_pct = 73;
        queue_weights(26, IN_RANGE);
        settle();

        // Spare profile code, oversized width; hold the output to back up the input
        set_config(PROF_SPARE, 4'd15, 4'd1);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        hold_req = 1'b1;
        queue_weights(66, VALUES_WILD);
        settle();

        set_config(PROF_Q4, 4'd0, 4'd1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_weight(8'hFF, 16'h8000, 32'h3C000000);
        add_weight(8'h00, 16'h7FFF, 32'h3C000000);
        add_weight(8'h02, 16'h0000, 32'h3C000000);
        add_weight(8'hFD, 16'hFFF8, 32'h3C000000);
        queue_weights(24, VALUES_WILD);
        settle();

        // Align to a block start so the first scale of the next block is inexact
        set_config(PROF_Q5, 4'd7, 4'd0);
        send_idle_pct = 73;
        queue_weights((BLOCK_ELEMENTS - elem_count) % BLOCK_ELEMENTS, VALUES_WILD);
        add_weight(8'h11, 16'h0000, 32'h3F800001);
        add_weight(8'h22, 16'h0000, 32'h33000000);
        add_weight(8'h33, 16'h0000, 32'h47800000);
        add_weight(8'h44, 16'h0000, 32'h7FC00000);
        add_weight(8'h55, 16'h0000, 32'h7F800000);
        add_weight(8'h66, 16'h0000, 32'h33C00000);
        queue_weights(25, SCALES_WILD);
        settle();

        set_config(PROF_Q8, 4'd8, 4'd1);
        send_idle_pct = 0;
        recv_stall_pct = 73;
        queue_weights(26, SCALES_WILD);
        settle();

        set_config(PROF_Q4, 4'd2, 4'd0);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        queue_weights(20, SCALES_WILD);
        settle();

        if (errors == 0)
            $display("quant_weight_block_packer_top_tb passed");
        else
            $display("quant_weight_block_packer_top_tb failed");
        $finish;
    end

endmodule
